/* design/three_segment_linear_curve_auc_core_defines.svh */
// Assertion macros shared by the curve core RTL.
`ifndef THREE_SEGMENT_LINEAR_CURVE_AUC_CORE_DEFINES_SVH
`define THREE_SEGMENT_LINEAR_CURVE_AUC_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TSLC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define TSLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tslc_pkg.sv */
// Types, constants and helpers for the three-segment curve core.
package tslc_pkg;

   localparam int DATA_W    = 32;
   localparam int AREA_W    = 48;
   localparam int WIDE_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_A_W   = 34;
   localparam int MUL_B_W   = 33;
   localparam int MUL_P_W   = 67;

   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_FIRST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK_SECOND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_FIRST  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE_SECOND = 3'd4;

   localparam logic [AREA_W-1:0] AREA_MAX = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INT_A,
      ST_INT_B,
      ST_INT_C,
      ST_INT_D,
      ST_VALUE,
      ST_AREA,
      ST_ACCUM,
      ST_FINAL,
      ST_PEAK_A,
      ST_PEAK_B
   } state_type;

   typedef enum logic [1:0] {
      SEG_BASE,
      SEG_FIRST,
      SEG_SECOND
   } seg_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = 64'sh0000_0000_7fff_ffff;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         return 32'sh7fff_ffff;
      end else if (v < lo) begin
         return -32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

endpackage

/* design/tslc_if.sv */
// Request and response channel interfaces of the curve core.
interface tslc_req_if;
   logic                          valid;
   logic                          ready;
   logic [tslc_pkg::DATA_W-1:0]   time_point;
   logic                          last_point;

   modport source (output valid, output time_point, output last_point, input ready);
   modport sink (input valid, input time_point, input last_point, output ready);
endinterface

interface tslc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tslc_pkg::DATA_W-1:0] curve_value;
   logic [tslc_pkg::AREA_W-1:0]        area;
   logic [tslc_pkg::DATA_W-1:0]        final_time;
   logic signed [tslc_pkg::DATA_W-1:0] final_uptake;
   logic signed [tslc_pkg::DATA_W-1:0] peak_value;
   logic signed [tslc_pkg::DATA_W-1:0] intercept_first;
   logic signed [tslc_pkg::DATA_W-1:0] intercept_second;
   logic                               summary_valid;

   modport source (output valid, output curve_value, output area, output final_time,
                   output final_uptake, output peak_value, output intercept_first,
                   output intercept_second, output summary_valid, input ready);
   modport sink (input valid, input curve_value, input area, input final_time,
                 input final_uptake, input peak_value, input intercept_first,
                 input intercept_second, input summary_valid, output ready);
endinterface

/* design/tslc_mul.sv */
// Shared registered multiplier: signed operand times unsigned operand.
module tslc_mul (
   input  logic                                 clock,
   input  logic signed [tslc_pkg::MUL_A_W-1:0]  a_in,
   input  logic [tslc_pkg::MUL_B_W-1:0]         b_in,
   output logic signed [tslc_pkg::MUL_P_W-1:0]  prod
);

   logic signed [tslc_pkg::MUL_A_W+tslc_pkg::MUL_B_W:0] full;
   logic signed [tslc_pkg::MUL_P_W-1:0]                 prod_ff;
   logic signed [tslc_pkg::MUL_P_W-1:0]                 prod_in;

   always_comb begin
      full    = a_in * $signed({1'b0, b_in});
      prod_in = full[tslc_pkg::MUL_P_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* design/three_segment_linear_curve_auc_core.sv */
// Top level: three-segment linear curve with trapezoidal area, one shared multiplier.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-----------------------------------------
//   req_bus  | in  | valid/ready       | time_point, last_point
//   rsp_bus  | out | valid/ready       | curve value, area and summary fields
//   csr_*    | in  | csr_wr_en only    | csr_index, csr_wdata (always taken)
//
// An ordinary point steps through accept, value, area multiply and accumulate; a point
// marked last then goes on to the final uptake and the two peak products. After any
// register write the next point first rebuilds the intercepts in ST_INT_A to ST_INT_D.
// All products go through the single registered multiplier. Reset is synchronous;
// one response register lets a new point enter while the previous beat waits, and
// the block holds in its last step while rsp_bus stalls.
module three_segment_linear_curve_auc_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   tslc_req_if.sink                            req_bus,
   tslc_rsp_if.source                          rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [tslc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tslc_pkg::DATA_W-1:0]         csr_wdata
);

`include "three_segment_linear_curve_auc_core_defines.svh"

   tslc_pkg::state_type state_ff, state_in;

   logic signed [31:0] baseline_ff, baseline_in;
   logic [31:0]        break_first_ff, break_first_in;
   logic [31:0]        break_second_ff, break_second_in;
   logic signed [31:0] slope_first_ff, slope_first_in;
   logic signed [31:0] slope_second_ff, slope_second_in;
   logic               dirty_ff, dirty_in;

   logic signed [63:0] b1_ff, b1_in;
   logic signed [63:0] b2_ff, b2_in;
   logic signed [63:0] vbs_ff, vbs_in;

   logic [31:0]        x_ff, x_in;
   logic               last_ff, last_in;
   logic signed [31:0] y_ff, y_in;
   logic signed [63:0] sfin_ff, sfin_in;
   logic [66:0]        m1_ff, m1_in;

   logic [31:0]        prev_time_ff, prev_time_in;
   logic signed [31:0] prev_value_ff, prev_value_in;
   logic               have_prev_ff, have_prev_in;
   logic [47:0]        area_sum_ff, area_sum_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_curve_ff, rsp_curve_in;
   logic [47:0]        rsp_area_ff, rsp_area_in;
   logic [31:0]        rsp_time_ff, rsp_time_in;
   logic signed [31:0] rsp_uptake_ff, rsp_uptake_in;
   logic signed [31:0] rsp_peak_ff, rsp_peak_in;
   logic signed [31:0] rsp_ic1_ff, rsp_ic1_in;
   logic signed [31:0] rsp_ic2_ff, rsp_ic2_in;
   logic               rsp_summary_ff, rsp_summary_in;

   // multiplier and operand paths
   logic signed [tslc_pkg::MUL_A_W-1:0] mul_a;
   logic [tslc_pkg::MUL_B_W-1:0]        mul_b;
   logic signed [tslc_pkg::MUL_P_W-1:0] prod;
   logic signed [tslc_pkg::MUL_P_W-1:0] prod_sh;
   logic signed [63:0]                  prod_q;

   logic [31:0]        x_src;
   tslc_pkg::seg_type  seg;
   logic signed [31:0] slope_sel;
   logic signed [63:0] base_wide;

   logic signed [32:0] dx, dx_neg;
   logic [31:0]        dx_mag;
   logic signed [32:0] ysum, ysum_neg;
   logic [32:0]        ysum_mag;
   logic signed [32:0] d1, d1_neg, d2, d2_neg;
   logic [31:0]        d1_mag, d2_mag;
   logic signed [32:0] s1_neg, s2_neg;
   logic [31:0]        s1_mag, s2_mag;

   logic [tslc_pkg::MUL_P_W-1:0] term;
   logic [67:0]                  area_wide;
   logic [47:0]                  area_next;
   logic signed [63:0]           y_wide;
   logic signed [63:0]           peak_wide;
   logic                         slot_free;

   tslc_mul u_mul (
      .clock (clock),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .prod  (prod)
   );

   assign prod_sh   = prod >>> FRAC_BITS;
   assign prod_q    = prod_sh[63:0];
   assign base_wide = {{32{baseline_ff[31]}}, baseline_ff};
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // operand preparation
   always_comb begin
      x_src = (state_ff == tslc_pkg::ST_IDLE) ? req_bus.time_point : x_ff;
      if (x_src < break_first_ff) begin
         seg = tslc_pkg::SEG_BASE;
      end else if (x_src <= break_second_ff) begin
         seg = tslc_pkg::SEG_FIRST;
      end else begin
         seg = tslc_pkg::SEG_SECOND;
      end
      slope_sel = (seg == tslc_pkg::SEG_SECOND) ? slope_second_ff : slope_first_ff;

      dx       = $signed({1'b0, x_ff}) - $signed({1'b0, prev_time_ff});
      dx_neg   = -dx;
      dx_mag   = dx[32] ? dx_neg[31:0] : dx[31:0];
      ysum     = $signed({y_ff[31], y_ff}) + $signed({prev_value_ff[31], prev_value_ff});
      ysum_neg = -ysum;
      ysum_mag = ysum[32] ? ysum_neg : ysum;

      d1     = $signed({1'b0, break_second_ff}) - $signed({1'b0, break_first_ff});
      d1_neg = -d1;
      d1_mag = d1[32] ? d1_neg[31:0] : d1[31:0];
      d2     = $signed({1'b0, x_ff}) - $signed({1'b0, break_second_ff});
      d2_neg = -d2;
      d2_mag = d2[32] ? d2_neg[31:0] : d2[31:0];

      s1_neg = -$signed({slope_first_ff[31], slope_first_ff});
      s1_mag = slope_first_ff[31] ? s1_neg[31:0] : slope_first_ff;
      s2_neg = -$signed({slope_second_ff[31], slope_second_ff});
      s2_mag = slope_second_ff[31] ? s2_neg[31:0] : slope_second_ff;

      term      = $unsigned(prod) >> (FRAC_BITS + 1);
      area_wide = 68'(term) + 68'(area_sum_ff);
      area_next = (area_wide > 68'(tslc_pkg::AREA_MAX)) ? tslc_pkg::AREA_MAX
                                                       : area_wide[47:0];

      case (seg)
         tslc_pkg::SEG_FIRST:  y_wide = prod_q + b1_ff;
         tslc_pkg::SEG_SECOND: y_wide = prod_q + b2_ff;
         default:              y_wide = base_wide;
      endcase

      if (!slope_first_ff[31] && !slope_second_ff[31]) begin
         peak_wide = sfin_ff;
      end else if (slope_first_ff[31] && slope_second_ff[31]) begin
         peak_wide = base_wide;
      end else if (slope_first_ff > 32'sd0 && slope_second_ff[31]) begin
         peak_wide = vbs_ff;
      end else begin
         peak_wide = (m1_ff >= $unsigned(prod)) ? base_wide : sfin_ff;
      end
   end

   // multiplier operand select per step
   always_comb begin
      case (state_ff)
         tslc_pkg::ST_IDLE, tslc_pkg::ST_INT_D: begin
            mul_a = {{2{slope_sel[31]}}, slope_sel};
            mul_b = {1'b0, x_src};
         end
         tslc_pkg::ST_INT_A: begin
            mul_a = {{2{slope_first_ff[31]}}, slope_first_ff};
            mul_b = {1'b0, break_first_ff};
         end
         tslc_pkg::ST_INT_B: begin
            mul_a = {{2{slope_first_ff[31]}}, slope_first_ff};
            mul_b = {1'b0, break_second_ff};
         end
         tslc_pkg::ST_INT_C: begin
            mul_a = {{2{slope_second_ff[31]}}, slope_second_ff};
            mul_b = {1'b0, break_second_ff};
         end
         tslc_pkg::ST_AREA: begin
            mul_a = {2'b00, dx_mag};
            mul_b = ysum_mag;
         end
         tslc_pkg::ST_ACCUM: begin
            // on a last point start the final uptake product, else hold the area product
            if (last_ff) begin
               mul_a = {{2{slope_second_ff[31]}}, slope_second_ff};
               mul_b = {1'b0, x_ff};
            end else begin
               mul_a = {2'b00, dx_mag};
               mul_b = ysum_mag;
            end
         end
         tslc_pkg::ST_FINAL: begin
            mul_a = {2'b00, s1_mag};
            mul_b = {1'b0, d1_mag};
         end
         tslc_pkg::ST_PEAK_A, tslc_pkg::ST_PEAK_B: begin
            mul_a = {2'b00, s2_mag};
            mul_b = {1'b0, d2_mag};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in        = state_ff;
      baseline_in     = baseline_ff;
      break_first_in  = break_first_ff;
      break_second_in = break_second_ff;
      slope_first_in  = slope_first_ff;
      slope_second_in = slope_second_ff;
      dirty_in        = dirty_ff;
      b1_in           = b1_ff;
      b2_in           = b2_ff;
      vbs_in          = vbs_ff;
      x_in            = x_ff;
      last_in         = last_ff;
      y_in            = y_ff;
      sfin_in         = sfin_ff;
      m1_in           = m1_ff;
      prev_time_in    = prev_time_ff;
      prev_value_in   = prev_value_ff;
      have_prev_in    = have_prev_ff;
      area_sum_in     = area_sum_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_curve_in    = rsp_curve_ff;
      rsp_area_in     = rsp_area_ff;
      rsp_time_in     = rsp_time_ff;
      rsp_uptake_in   = rsp_uptake_ff;
      rsp_peak_in     = rsp_peak_ff;
      rsp_ic1_in      = rsp_ic1_ff;
      rsp_ic2_in      = rsp_ic2_ff;
      rsp_summary_in  = rsp_summary_ff;

      case (state_ff)
         tslc_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               x_in     = req_bus.time_point;
               last_in  = req_bus.last_point;
               state_in = dirty_ff ? tslc_pkg::ST_INT_A : tslc_pkg::ST_VALUE;
            end
         end
         tslc_pkg::ST_INT_A: begin
            state_in = tslc_pkg::ST_INT_B;
         end
         tslc_pkg::ST_INT_B: begin
            b1_in    = base_wide - prod_q;
            state_in = tslc_pkg::ST_INT_C;
         end
         tslc_pkg::ST_INT_C: begin
            vbs_in   = prod_q + b1_ff;
            state_in = tslc_pkg::ST_INT_D;
         end
         tslc_pkg::ST_INT_D: begin
            b2_in    = vbs_ff - prod_q;
            dirty_in = 1'b0;
            state_in = tslc_pkg::ST_VALUE;
         end
         tslc_pkg::ST_VALUE: begin
            y_in     = tslc_pkg::sat32(y_wide);
            state_in = tslc_pkg::ST_AREA;
         end
         tslc_pkg::ST_AREA: begin
            state_in = tslc_pkg::ST_ACCUM;
         end
         tslc_pkg::ST_ACCUM: begin
            if (last_ff) begin
               if (have_prev_ff) begin
                  area_sum_in = area_next;
               end
               prev_time_in  = '0;
               prev_value_in = '0;
               have_prev_in  = 1'b0;
               state_in      = tslc_pkg::ST_FINAL;
            end else if (slot_free) begin
               if (have_prev_ff) begin
                  area_sum_in = area_next;
               end
               prev_time_in   = x_ff;
               prev_value_in  = y_ff;
               have_prev_in   = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_curve_in   = y_ff;
               rsp_area_in    = '0;
               rsp_time_in    = '0;
               rsp_uptake_in  = '0;
               rsp_peak_in    = '0;
               rsp_ic1_in     = tslc_pkg::sat32(b1_ff);
               rsp_ic2_in     = tslc_pkg::sat32(b2_ff);
               rsp_summary_in = 1'b0;
               state_in       = tslc_pkg::ST_IDLE;
            end
         end
         tslc_pkg::ST_FINAL: begin
            sfin_in  = prod_q + b2_ff;
            state_in = tslc_pkg::ST_PEAK_A;
         end
         tslc_pkg::ST_PEAK_A: begin
            m1_in    = $unsigned(prod);
            state_in = tslc_pkg::ST_PEAK_B;
         end
         tslc_pkg::ST_PEAK_B: begin
            // hold here until the response register frees up
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_curve_in   = y_ff;
               rsp_area_in    = area_sum_ff;
               rsp_time_in    = x_ff;
               rsp_uptake_in  = tslc_pkg::sat32(sfin_ff);
               rsp_peak_in    = tslc_pkg::sat32(peak_wide);
               rsp_ic1_in     = tslc_pkg::sat32(b1_ff);
               rsp_ic2_in     = tslc_pkg::sat32(b2_ff);
               rsp_summary_in = 1'b1;
               area_sum_in    = '0;
               state_in       = tslc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tslc_pkg::ST_IDLE;
         end
      endcase

      // register writes; mark intercepts stale
      if (csr_wr_en) begin
         dirty_in = 1'b1;
         case (csr_index)
            tslc_pkg::CSR_BASELINE:     baseline_in     = $signed(csr_wdata);
            tslc_pkg::CSR_BREAK_FIRST:  break_first_in  = csr_wdata;
            tslc_pkg::CSR_BREAK_SECOND: break_second_in = csr_wdata;
            tslc_pkg::CSR_SLOPE_FIRST:  slope_first_in  = $signed(csr_wdata);
            tslc_pkg::CSR_SLOPE_SECOND: slope_second_in = $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tslc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff     <= '0;
         break_first_ff  <= '0;
         break_second_ff <= '0;
         slope_first_ff  <= '0;
         slope_second_ff <= '0;
         dirty_ff        <= 1'b0;
         b1_ff           <= '0;
         b2_ff           <= '0;
         vbs_ff          <= '0;
         prev_time_ff    <= '0;
         prev_value_ff   <= '0;
         have_prev_ff    <= 1'b0;
         area_sum_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         baseline_ff     <= baseline_in;
         break_first_ff  <= break_first_in;
         break_second_ff <= break_second_in;
         slope_first_ff  <= slope_first_in;
         slope_second_ff <= slope_second_in;
         dirty_ff        <= dirty_in;
         b1_ff           <= b1_in;
         b2_ff           <= b2_in;
         vbs_ff          <= vbs_in;
         prev_time_ff    <= prev_time_in;
         prev_value_ff   <= prev_value_in;
         have_prev_ff    <= have_prev_in;
         area_sum_ff     <= area_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      last_ff        <= last_in;
      y_ff           <= y_in;
      sfin_ff        <= sfin_in;
      m1_ff          <= m1_in;
      rsp_curve_ff   <= rsp_curve_in;
      rsp_area_ff    <= rsp_area_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_uptake_ff  <= rsp_uptake_in;
      rsp_peak_ff    <= rsp_peak_in;
      rsp_ic1_ff     <= rsp_ic1_in;
      rsp_ic2_ff     <= rsp_ic2_in;
      rsp_summary_ff <= rsp_summary_in;
   end

   assign req_bus.ready            = (state_ff == tslc_pkg::ST_IDLE);
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.curve_value      = rsp_curve_ff;
   assign rsp_bus.area             = rsp_area_ff;
   assign rsp_bus.final_time       = rsp_time_ff;
   assign rsp_bus.final_uptake     = rsp_uptake_ff;
   assign rsp_bus.peak_value       = rsp_peak_ff;
   assign rsp_bus.intercept_first  = rsp_ic1_ff;
   assign rsp_bus.intercept_second = rsp_ic2_ff;
   assign rsp_bus.summary_valid    = rsp_summary_ff;

   `TSLC_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_bus.valid && req_bus.ready, !req_bus.ready, "ready high right after accept")

   `TSLC_ASSERT_NOW(a_plain_beat_no_summary, clock, reset,
      rsp_bus.valid && !rsp_bus.summary_valid,
      rsp_bus.area == '0 && rsp_bus.final_time == '0, "summary fields set on plain beat")

   `TSLC_ASSERT_NOW(a_series_cleared, clock, reset,
      rsp_bus.valid && rsp_bus.ready && rsp_bus.summary_valid,
      area_sum_ff == '0 && !have_prev_ff, "series state not cleared after last point")

endmodule
